[rtl/pip_pkg.sv]
package pip_pkg;

    // Width of every coordinate field on the ports
    localparam int FIELD_W = 16;

    // Entries in the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Per-item edge decisions made in the front
    typedef struct packed {
        logic step_cand;   // step edge straddles the ray line
        logic step_det;    // step edge: p.y - q.y > 0
        logic close_cand;  // closing edge straddles the ray line
        logic close_det;   // closing edge: p.y - q.y > 0
        logic first;
        logic last;
    } t_edge_flags;

endpackage

[rtl/pip_front.sv]
module pip_front
    import pip_pkg::*;
#(
    parameter int COORD_WIDTH = 16,
    parameter int EW = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [FIELD_W-1:0] i_query_x,
    input  logic [FIELD_W-1:0] i_query_y,
    input  logic [FIELD_W-1:0] i_vertex_x,
    input  logic [FIELD_W-1:0] i_vertex_y,
    input  logic               i_first_vertex,
    input  logic               i_last_vertex,
    output logic [EW-1:0]      o_entry
);

    localparam bit ZX = COORD_WIDTH > FIELD_W;
    localparam int SW = ZX ? FIELD_W : COORD_WIDTH;
    localparam int VW = ZX ? FIELD_W + 1 : COORD_WIDTH;
    localparam int DW = VW + 1;

    function automatic logic signed [VW-1:0] f_ext(input logic [FIELD_W-1:0] raw);
        logic [SW-1:0] t;
        t = raw[SW-1:0];
        if (ZX) begin
            return VW'({1'b0, t});
        end else begin
            return VW'(signed'(t));
        end
    endfunction

    logic signed [VW-1:0] r_qx, r_qy, r_ox, r_oy, r_vx, r_vy;
    logic signed [VW-1:0] cur_x, cur_y, q_x, q_y, open_x, open_y;
    logic signed [DW-1:0] spx, spy, sqx, sqy, cpx, cpy, cqx, cqy;
    t_edge_flags          flags;

    always_comb begin
        cur_x  = f_ext(i_vertex_x);
        cur_y  = f_ext(i_vertex_y);
        q_x    = i_first_vertex ? f_ext(i_query_x) : r_qx;
        q_y    = i_first_vertex ? f_ext(i_query_y) : r_qy;
        open_x = i_first_vertex ? cur_x : r_ox;
        open_y = i_first_vertex ? cur_y : r_oy;

        // Step edge: previous -> current; closing edge: current -> opening
        spx = DW'(r_vx) - DW'(q_x);
        spy = DW'(r_vy) - DW'(q_y);
        sqx = DW'(cur_x) - DW'(q_x);
        sqy = DW'(cur_y) - DW'(q_y);
        cpx = sqx;
        cpy = sqy;
        cqx = DW'(open_x) - DW'(q_x);
        cqy = DW'(open_y) - DW'(q_y);

        flags.step_cand  = !i_first_vertex && ((spy > 0) != (sqy > 0));
        flags.step_det   = spy > sqy;
        flags.close_cand = (cpy > 0) != (cqy > 0);
        flags.close_det  = cpy > cqy;
        flags.first      = i_first_vertex;
        flags.last       = i_last_vertex;

        o_entry = {flags, spx, spy, sqx, sqy, cpx, cpy, cqx, cqy};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qx <= '0;
            r_qy <= '0;
            r_ox <= '0;
            r_oy <= '0;
            r_vx <= '0;
            r_vy <= '0;
        end else if (i_accept) begin
            r_qx <= q_x;
            r_qy <= q_y;
            r_ox <= open_x;
            r_oy <= open_y;
            r_vx <= cur_x;
            r_vy <= cur_y;
        end
    end

endmodule

[rtl/pip_queue.sv]
module pip_queue
    import pip_pkg::*;
#(
    parameter int EW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [EW-1:0] i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output logic [EW-1:0] o_data
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [EW-1:0] r_mem [QUEUE_DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;

    assign o_full  = r_cnt == CW'(QUEUE_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == AW'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == AW'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

[rtl/pip_back.sv]
module pip_back
    import pip_pkg::*;
#(
    parameter int COORD_WIDTH = 16,
    parameter int EW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [EW-1:0] i_entry,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic          o_inside_res
);

    localparam bit ZX = COORD_WIDTH > FIELD_W;
    localparam int VW = ZX ? FIELD_W + 1 : COORD_WIDTH;
    localparam int DW = VW + 1;
    localparam int PW = 2 * DW;
    localparam int XW = PW + 1;

    function automatic logic f_counts(input logic signed [XW-1:0] cr, input logic det);
        return (cr == '0) || ((cr > 0) == det);
    endfunction

    t_edge_flags          in_flags;
    logic signed [DW-1:0] spx, spy, sqx, sqy, cpx, cpy, cqx, cqy;

    t_edge_flags          r_flags;
    logic                 r_s1_valid;
    logic signed [PW-1:0] r_s_a, r_s_b, r_c_a, r_c_b;
    logic                 r_parity;
    logic                 r_out_valid;
    logic                 r_out;

    logic                 s1_adv, s1_ready;
    logic signed [XW-1:0] s_cr, c_cr;
    logic                 n_parity;

    assign {in_flags, spx, spy, sqx, sqy, cpx, cpy, cqx, cqy} = i_entry;

    // Non-last items drain freely; a last item waits for the output register
    assign s1_adv   = r_s1_valid && (!r_flags.last || !r_out_valid || i_ready);
    assign s1_ready = !r_s1_valid || s1_adv;
    assign o_pop    = i_valid && s1_ready;

    always_comb begin
        s_cr     = XW'(r_s_a) - XW'(r_s_b);
        c_cr     = XW'(r_c_a) - XW'(r_c_b);
        n_parity = r_flags.first ? 1'b0 : r_parity;
        if (r_flags.step_cand && f_counts(s_cr, r_flags.step_det)) begin
            n_parity = !n_parity;
        end
        if (r_flags.last && r_flags.close_cand && f_counts(c_cr, r_flags.close_det)) begin
            n_parity = !n_parity;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready) begin
            r_flags <= in_flags;
            r_s_a   <= PW'(sqx) * PW'(spy);
            r_s_b   <= PW'(sqy) * PW'(spx);
            r_c_a   <= PW'(cqx) * PW'(cpy);
            r_c_b   <= PW'(cqy) * PW'(cpx);
        end
        if (s1_adv && r_flags.last) begin
            r_out <= n_parity;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_parity    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_s1_valid <= i_valid;
            end
            if (s1_adv) begin
                r_parity <= n_parity;
            end
            if (s1_adv && r_flags.last) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_inside_res = r_out;

endmodule

[rtl/point_in_polygon_crossing_top.sv]
// Crossing-number point-in-polygon test, one vertex per item.
// A last vertex is queued, then its products are registered, then its result.
// Throughput: one vertex per cycle while i_ready takes results; the front subtract
// and back product stages take one item a cycle, joined by a two-entry queue.
// Reset (i_rst_n low, synchronous) clears the held points, parity and all valids.
module point_in_polygon_crossing_top
    import pip_pkg::*;
#(
    parameter int COORD_WIDTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [FIELD_W-1:0] i_query_x,
    input  logic [FIELD_W-1:0] i_query_y,
    input  logic [FIELD_W-1:0] i_vertex_x,
    input  logic [FIELD_W-1:0] i_vertex_y,
    input  logic               i_first_vertex,
    input  logic               i_last_vertex,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_inside_res
);

    localparam int VW = (COORD_WIDTH > FIELD_W) ? FIELD_W + 1 : COORD_WIDTH;
    localparam int DW = VW + 1;
    localparam int EW = 8 * DW + $bits(t_edge_flags);

    logic          accept;
    logic          q_full, q_valid, q_pop;
    logic [EW-1:0] front_entry, q_entry;

    assign o_ready = !q_full;
    assign accept  = i_valid && !q_full;

    pip_front #(
        .COORD_WIDTH(COORD_WIDTH),
        .EW         (EW)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_query_x     (i_query_x),
        .i_query_y     (i_query_y),
        .i_vertex_x    (i_vertex_x),
        .i_vertex_y    (i_vertex_y),
        .i_first_vertex(i_first_vertex),
        .i_last_vertex (i_last_vertex),
        .o_entry       (front_entry)
    );

    pip_queue #(
        .EW(EW)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (accept),
        .i_data (front_entry),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_valid(q_valid),
        .o_data (q_entry)
    );

    pip_back #(
        .COORD_WIDTH(COORD_WIDTH),
        .EW         (EW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_entry     (q_entry),
        .o_pop       (q_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_inside_res(o_inside_res)
    );

endmodule

[tb/point_in_polygon_crossing_top_test.sv]
module point_in_polygon_crossing_top_test;
    import pip_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_W      = 16;
    localparam int TOTAL_ITEMS  = 1950;
    localparam int STALL_LIMIT  = 5000;
    localparam int HOLD_CYCLES  = 150;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_REPORTS  = 10;

    typedef enum bit {
        EXP_PREDICTED,
        EXP_FIXED
    } t_exp_src;

    typedef struct packed {
        logic signed [FIELD_W-1:0] qx;
        logic signed [FIELD_W-1:0] qy;
        logic signed [FIELD_W-1:0] vx;
        logic signed [FIELD_W-1:0] vy;
        bit                        first;
        bit                        last;
        t_exp_src                  src;
        bit                        want;
    } t_dir_row;

    typedef struct {
        longint x;
        longint y;
    } t_point;

    // query x, query y, vertex x, vertex y, first, last, expectation, fixed value
    localparam t_dir_row DIRECTED [25] = '{
        // vertices before any first mark run on the cleared state
        '{123, -77, 5, -3, 0, 0, EXP_PREDICTED, 0},
        '{-9, 41, 7, 4, 0, 1, EXP_PREDICTED, 0},
        // one-vertex polygon
        '{100, 100, 3, 3, 1, 1, EXP_FIXED, 0},
        // square around the query point
        '{0, 0, -10, -10, 1, 0, EXP_PREDICTED, 0},
        '{0, 0, 10, -10, 0, 0, EXP_PREDICTED, 0},
        '{0, 0, 10, 10, 0, 0, EXP_PREDICTED, 0},
        '{0, 0, -10, 10, 0, 1, EXP_FIXED, 1},
        // same square, query to the right; query fields ignored after the first
        '{50, 0, -10, -10, 1, 0, EXP_PREDICTED, 0},
        '{-1, -1, 10, -10, 0, 0, EXP_PREDICTED, 0},
        '{0, 0, 10, 10, 0, 0, EXP_PREDICTED, 0},
        '{0, 0, -10, 10, 0, 1, EXP_FIXED, 0},
        // vertex sitting on the ray
        '{0, 0, 5, 0, 1, 0, EXP_PREDICTED, 0},
        '{0, 0, -5, 5, 0, 0, EXP_PREDICTED, 0},
        '{0, 0, -5, -5, 0, 1, EXP_PREDICTED, 0},
        // horizontal edge along the ray
        '{0, 0, -5, 0, 1, 0, EXP_PREDICTED, 0},
        '{0, 0, 5, 0, 0, 0, EXP_PREDICTED, 0},
        '{0, 0, 0, 5, 0, 1, EXP_PREDICTED, 0},
        // keep going after a last mark without a new first mark
        '{777, -777, 0, -5, 0, 0, EXP_PREDICTED, 0},
        '{-1, 1, 3, 3, 0, 1, EXP_PREDICTED, 0},
        // coordinate extremes
        '{-32768, -32768, 32767, 32767, 1, 0, EXP_PREDICTED, 0},
        '{32767, 32767, -32768, 32767, 0, 0, EXP_PREDICTED, 0},
        '{0, 0, -32768, -32768, 0, 0, EXP_PREDICTED, 0},
        '{-1, -1, 32767, -32768, 0, 1, EXP_PREDICTED, 0},
        '{32767, 32767, -32768, -32768, 1, 0, EXP_PREDICTED, 0},
        '{-32768, -32768, 32767, 32767, 0, 1, EXP_PREDICTED, 0}
    };

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [FIELD_W-1:0] i_query_x;
    logic [FIELD_W-1:0] i_query_y;
    logic [FIELD_W-1:0] i_vertex_x;
    logic [FIELD_W-1:0] i_vertex_y;
    logic               i_first_vertex;
    logic               i_last_vertex;
    logic               o_valid;
    logic               i_ready;
    logic               o_inside_res;

    t_point query_pt;
    t_point start_pt;
    t_point prev_pt;
    bit     parity;

    bit expected_inside_q[$];
    int send_idle_pct;
    int recv_idle_pct;
    int phase;
    int vertices_sent;
    int results_seen;
    int inside_seen;
    int failures;

    point_in_polygon_crossing_top #(
        .COORD_WIDTH(COORD_W)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_query_x     (i_query_x),
        .i_query_y     (i_query_y),
        .i_vertex_x    (i_vertex_x),
        .i_vertex_y    (i_vertex_y),
        .i_first_vertex(i_first_vertex),
        .i_last_vertex (i_last_vertex),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_inside_res  (o_inside_res)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic longint to_coord(logic [FIELD_W-1:0] raw);
        longint v;
        v = longint'(raw) & ((longint'(1) << COORD_W) - 1);
        if (v[COORD_W-1]) begin
            v = v - (longint'(1) << COORD_W);
        end
        return v;
    endfunction

    // Half-open straddle, then crossing x at or right of the query point
    function automatic bit ray_crossed(t_point a, t_point b);
        longint px, py, qx, qy, dy, cr;
        px = a.x - query_pt.x;
        py = a.y - query_pt.y;
        qx = b.x - query_pt.x;
        qy = b.y - query_pt.y;
        if ((py > 0) == (qy > 0)) begin
            return 1'b0;
        end
        dy = py - qy;
        cr = qx * py - qy * px;
        return (cr == 0) || ((cr > 0) == (dy > 0));
    endfunction

    function automatic bit advance_polygon(input logic [FIELD_W-1:0] qx_f, qy_f, vx_f, vy_f,
                                           input bit first, last, output bit in_poly);
        t_point cur;
        cur.x = to_coord(vx_f);
        cur.y = to_coord(vy_f);
        if (first) begin
            query_pt.x = to_coord(qx_f);
            query_pt.y = to_coord(qy_f);
            start_pt   = cur;
            parity     = 1'b0;
        end else if (ray_crossed(prev_pt, cur)) begin
            parity ^= 1'b1;
        end
        prev_pt = cur;
        in_poly = 1'b0;
        if (last) begin
            if (ray_crossed(cur, start_pt)) begin
                parity ^= 1'b1;
            end
            in_poly = parity;
        end
        return last;
    endfunction

    function automatic logic [FIELD_W-1:0] near(logic [FIELD_W-1:0] c, int span);
        return c + FIELD_W'($urandom_range(0, 2 * span) - span);
    endfunction

    task automatic report_failure(string msg);
        failures++;
        if (failures <= MAX_REPORTS) begin
            $display("%0t: %s", $realtime, msg);
        end
    endtask

    // Offer one item, hold it until accepted, then predict its result
    task automatic offer(input logic [FIELD_W-1:0] qx, qy, vx, vy, input bit first, last,
                         input t_exp_src src, input bit want);
        bit lowered;
        bit in_poly;
        lowered = 1'b0;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            if (!lowered) begin
                i_valid <= 1'b0;
                lowered = 1'b1;
            end
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_query_x      <= qx;
        i_query_y      <= qy;
        i_vertex_x     <= vx;
        i_vertex_y     <= vy;
        i_first_vertex <= first;
        i_last_vertex  <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        vertices_sent++;
        if (advance_polygon(qx, qy, vx, vy, first, last, in_poly)) begin
            expected_inside_q.push_back(src == EXP_FIXED ? want : in_poly);
        end
    endtask

    task automatic set_phase();
        if (vertices_sent < TOTAL_ITEMS / 3) begin
            phase = 0;
            send_idle_pct = 33;
            recv_idle_pct = 57;
        end else if (vertices_sent < 2 * TOTAL_ITEMS / 3) begin
            phase = 1;
            send_idle_pct = 57;
            recv_idle_pct = 33;
        end else begin
            phase = 2;
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    endtask

    // Mostly well-formed polygons; a few lose a mark, some items are pure noise
    task automatic send_random_polygon();
        int n, mode;
        bit drop_first, drop_last, first, last;
        logic [FIELD_W-1:0] qx, qy, vx, vy;
        if ($urandom_range(0, 9) == 0) begin
            offer(FIELD_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom),
                  FIELD_W'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  EXP_PREDICTED, 1'b0);
            return;
        end
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
        mode = $urandom_range(0, 3);
        drop_first = ($urandom_range(0, 19) == 0);
        drop_last  = ($urandom_range(0, 19) == 0);
        if (mode == 2) begin
            qx = FIELD_W'($urandom_range(0, 8) - 4);
            qy = FIELD_W'($urandom_range(0, 8) - 4);
        end else begin
            qx = FIELD_W'($urandom);
            qy = FIELD_W'($urandom);
        end
        for (int k = 0; k < n; k++) begin
            case (mode)
                0: begin
                    vx = near(qx, 20);
                    vy = near(qy, 20);
                end
                1: begin
                    vx = FIELD_W'($urandom);
                    vy = FIELD_W'($urandom);
                end
                2: begin
                    vx = FIELD_W'($urandom_range(0, 8) - 4);
                    vy = FIELD_W'($urandom_range(0, 8) - 4);
                end
                default: begin
                    // many vertices on or next to the ray line
                    vx = FIELD_W'($urandom);
                    vy = near(qy, 2);
                end
            endcase
            first = (k == 0) && !drop_first;
            last  = (k == n - 1) && !drop_last;
            if (first) begin
                offer(qx, qy, vx, vy, first, last, EXP_PREDICTED, 1'b0);
            end else begin
                offer(FIELD_W'($urandom), FIELD_W'($urandom), vx, vy, first, last,
                      EXP_PREDICTED, 1'b0);
            end
        end
    endtask

    initial begin
        int hold_left;
        bit pressure_done;
        hold_left     = 0;
        pressure_done = 1'b0;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (phase == 2 && !pressure_done) begin
                hold_left     = HOLD_CYCLES;
                pressure_done = 1'b1;
            end
            if (hold_left > 0) begin
                i_ready <= 1'b0;
                hold_left--;
            end else begin
                i_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && i_ready) begin
            results_seen++;
            if (o_inside_res === 1'b1) begin
                inside_seen++;
            end
            if (expected_inside_q.size() == 0) begin
                report_failure($sformatf("unexpected result inside_res=%b", o_inside_res));
            end else if (o_inside_res !== expected_inside_q[0]) begin
                report_failure($sformatf("result %0d: inside_res expected %b, got %b",
                                         results_seen, expected_inside_q[0], o_inside_res));
                void'(expected_inside_q.pop_front());
            end else begin
                void'(expected_inside_q.pop_front());
            end
        end
    end

    initial begin
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
        end
        $display("Timeout: no item moved for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, expected_inside_q.size());
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        query_pt       = '{0, 0};
        start_pt       = '{0, 0};
        prev_pt        = '{0, 0};
        parity         = 1'b0;
        phase          = 0;
        send_idle_pct  = 33;
        recv_idle_pct  = 57;
        vertices_sent  = 0;
        results_seen   = 0;
        inside_seen    = 0;
        failures       = 0;
        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_query_x      <= '0;
        i_query_y      <= '0;
        i_vertex_x     <= '0;
        i_vertex_y     <= '0;
        i_first_vertex <= 1'b0;
        i_last_vertex  <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[i]) begin
            offer(DIRECTED[i].qx, DIRECTED[i].qy, DIRECTED[i].vx, DIRECTED[i].vy,
                  DIRECTED[i].first, DIRECTED[i].last, DIRECTED[i].src, DIRECTED[i].want);
        end
        while (vertices_sent < TOTAL_ITEMS) begin
            set_phase();
            send_random_polygon();
        end
        i_valid <= 1'b0;

        while (expected_inside_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_inside_q.size() != 0) begin
            report_failure($sformatf("%0d results never arrived", expected_inside_q.size()));
        end

        $display("Ran %0d vertices, %0d polygon results (%0d inside), %0d mismatches.",
                 vertices_sent, results_seen, inside_seen, failures);
        $display("Both idle mixes, a %0d-cycle output hold-off, then back-to-back streaming.",
                 HOLD_CYCLES);
        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

[files.f]
rtl/pip_pkg.sv
rtl/pip_front.sv
rtl/pip_queue.sv
rtl/pip_back.sv
rtl/point_in_polygon_crossing_top.sv
tb/point_in_polygon_crossing_top_test.sv
